### rtl/tun_pkg.sv
// Shared payload types and fixed field widths for the triangle unit normal block.
package tun_pkg;

  // Vertex coordinate width and result component width
  localparam int unsigned TUN_COORD_W = 12;
  localparam int unsigned TUN_NORM_W  = 16;

  typedef struct packed {
    logic signed [TUN_COORD_W-1:0] a_x;
    logic signed [TUN_COORD_W-1:0] a_y;
    logic signed [TUN_COORD_W-1:0] a_z;
    logic signed [TUN_COORD_W-1:0] b_x;
    logic signed [TUN_COORD_W-1:0] b_y;
    logic signed [TUN_COORD_W-1:0] b_z;
    logic signed [TUN_COORD_W-1:0] c_x;
    logic signed [TUN_COORD_W-1:0] c_y;
    logic signed [TUN_COORD_W-1:0] c_z;
  } tun_in_t;

  typedef struct packed {
    logic signed [TUN_NORM_W-1:0] normal_x;
    logic signed [TUN_NORM_W-1:0] normal_y;
    logic signed [TUN_NORM_W-1:0] normal_z;
    logic                         degenerate;
  } tun_out_t;

endpackage

### rtl/tun_sqrt_cell.sv
// One cell of the integer square root chain: resolves one root bit per cycle while en is high.
module tun_sqrt_cell #(
  parameter int unsigned RW = 27
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] rad_i,
  input  logic [RW+1:0]   rem_i,
  input  logic [RW-1:0]   root_i,
  output logic [2*RW-1:0] rad_r,
  output logic [RW+1:0]   rem_r,
  output logic [RW-1:0]   root_r
);

  logic [RW+1:0] part;
  logic [RW+1:0] trial;
  logic          ge;

  // Bring down the next two radicand bits and try root bit one
  assign part  = {rem_i[RW-1:0], rad_i[2*RW-1 -: 2]};
  assign trial = {root_i, 2'b01};
  assign ge    = (part >= trial);

  // Advance the partial root and remainder
  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= {rad_i[2*RW-3:0], 2'b00};
      rem_r  <= ge ? (part - trial) : part;
      root_r <= {root_i[RW-2:0], ge};
    end
  end

endmodule

### rtl/tun_div_cell.sv
// One cell of the restoring divider chain: resolves one quotient bit per cycle while en is high.
module tun_div_cell #(
  parameter int unsigned LW = 27,
  parameter int unsigned QW = 15
) (
  input  logic          clk,
  input  logic          en,
  input  logic [LW-1:0] rem_i,
  input  logic          bit_i,
  input  logic [LW-1:0] len_i,
  input  logic [QW-1:0] q_i,
  output logic [LW-1:0] rem_r,
  output logic [QW-1:0] q_r
);

  logic [LW:0] part;
  logic [LW:0] diff;
  logic        ge;

  // Shift in the next dividend bit and compare against the length
  assign part = {rem_i, bit_i};
  assign diff = part - {1'b0, len_i};
  assign ge   = (part >= {1'b0, len_i});

  // Advance remainder and quotient
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= ge ? diff[LW-1:0] : part[LW-1:0];
      q_r   <= {q_i[QW-2:0], ge};
    end
  end

endmodule

### rtl/triangle_unit_normal.sv
// Unit surface normal of one triangle per transfer: cross product, root chain, divider chain.
//
// One triangle is accepted per clock unless every stage is full and the output
// is held, and each gives one result. The pipeline runs through the cross
// product and squared length stages, the square root chain (one cell per root
// bit), the divider chain (one cell per quotient bit, three lanes side by side)
// and a final packing stage. Each stage holds its own valid bit and moves
// forward whenever the stage after it is free, so empty stages close up and
// input is taken while a result waits at the output. Components are N/|N| in
// signed fixed point with FRAC_BITS fraction bits, truncated toward zero, kept
// to the low 16 bits; a zero cross product gives a zero vector with degenerate set.
module triangle_unit_normal
  import tun_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  tun_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output tun_out_t out_data
);

  localparam int unsigned EW  = TUN_COORD_W + 1;
  localparam int unsigned NW  = 2 * EW + 1;
  localparam int unsigned MW  = 2 * EW;
  localparam int unsigned RW  = MW + 1;
  localparam int unsigned SW  = 2 * RW;
  localparam int unsigned QW  = FRAC_BITS + 1;
  localparam int unsigned SQ0 = 4;
  localparam int unsigned DV0 = SQ0 + RW;
  localparam int unsigned PK  = DV0 + QW;
  localparam int unsigned NS  = PK + 1;

  // Stage valid bits and per-stage advance
  logic [NS-1:0] v_r;
  logic [NS:0]   en;
  logic [NS-1:0] v_in;

  assign en[NS] = out_ready;
  assign v_in   = {v_r[NS-2:0], in_valid};

  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = !v_r[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) v_r[k] <= v_in[k];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NS-1];

  // Edges of the triangle
  logic signed [EW-1:0] ux, uy, uz, vx, vy, vz;
  assign ux = EW'(in_data.b_x) - EW'(in_data.a_x);
  assign uy = EW'(in_data.b_y) - EW'(in_data.a_y);
  assign uz = EW'(in_data.b_z) - EW'(in_data.a_z);
  assign vx = EW'(in_data.c_x) - EW'(in_data.a_x);
  assign vy = EW'(in_data.c_y) - EW'(in_data.a_y);
  assign vz = EW'(in_data.c_z) - EW'(in_data.a_z);

  // Stage 0: cross product terms
  logic signed [MW-1:0] p_r [6];
  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_r[0] <= uy * vz;
      p_r[1] <= uz * vy;
      p_r[2] <= uz * vx;
      p_r[3] <= ux * vz;
      p_r[4] <= ux * vy;
      p_r[5] <= uy * vx;
    end
  end

  // Stage 1: cross product components
  logic signed [NW-1:0] n1_r [3];
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int l = 0; l < 3; l++) begin
        n1_r[l] <= NW'(p_r[2*l]) - NW'(p_r[2*l+1]);
      end
    end
  end

  // Stage 2: squares of the magnitudes, zero test
  logic [MW-1:0]        mag1 [3];
  logic [2*MW-1:0]      sq2_r [3];
  logic signed [NW-1:0] n2_r [3];
  logic                 deg2_r;

  for (genvar l = 0; l < 3; l++) begin : g_mag1
    assign mag1[l] = n1_r[l][NW-1] ? MW'(-n1_r[l]) : MW'(n1_r[l]);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int l = 0; l < 3; l++) begin
        sq2_r[l] <= mag1[l] * mag1[l];
        n2_r[l]  <= n1_r[l];
      end
      deg2_r <= (n1_r[0] == '0) && (n1_r[1] == '0) && (n1_r[2] == '0);
    end
  end

  // Stage 3: squared length
  logic [SW-1:0]        rad3_r;
  logic signed [NW-1:0] n3_r [3];
  logic                 deg3_r;
  always_ff @(posedge clk) begin
    if (en[3]) begin
      rad3_r <= SW'(sq2_r[0]) + SW'(sq2_r[1]) + SW'(sq2_r[2]);
      n3_r   <= n2_r;
      deg3_r <= deg2_r;
    end
  end

  // Square root chain, one root bit per cell
  logic [SW-1:0]        sq_rad  [RW+1];
  logic [RW+1:0]        sq_rem  [RW+1];
  logic [RW-1:0]        sq_root [RW+1];
  logic signed [NW-1:0] sq_n    [RW+1][3];
  logic                 sq_deg  [RW+1];

  assign sq_rad[0]  = rad3_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_n[0]    = n3_r;
  assign sq_deg[0]  = deg3_r;

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    tun_sqrt_cell #(.RW(RW)) u_cell (
      .clk    (clk),
      .en     (en[SQ0+k]),
      .rad_i  (sq_rad[k]),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .rad_r  (sq_rad[k+1]),
      .rem_r  (sq_rem[k+1]),
      .root_r (sq_root[k+1])
    );

    // Carry the components and zero flag alongside
    logic signed [NW-1:0] n_r [3];
    logic                 deg_r;
    always_ff @(posedge clk) begin
      if (en[SQ0+k]) begin
        n_r   <= sq_n[k];
        deg_r <= sq_deg[k];
      end
    end
    assign sq_n[k+1]   = n_r;
    assign sq_deg[k+1] = deg_r;
  end

  // Divider chain, three lanes, one quotient bit per cell
  logic [MW-1:0] mag_d [3];
  logic [RW-1:0] dv_rem [3][QW+1];
  logic [QW-1:0] dv_q   [3][QW+1];
  logic [RW-1:0] dv_len [QW+1];
  logic [2:0]    dv_neg [QW+1];
  logic          dv_deg [QW+1];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    assign mag_d[l] = sq_n[RW][l][NW-1] ? MW'(-sq_n[RW][l]) : MW'(sq_n[RW][l]);
    assign dv_rem[l][0] = RW'(mag_d[l] >> 1);
    assign dv_q[l][0]   = '0;
    assign dv_neg[0][l] = sq_n[RW][l][NW-1];

    for (genvar k = 0; k < QW; k++) begin : g_div
      tun_div_cell #(.LW(RW), .QW(QW)) u_cell (
        .clk   (clk),
        .en    (en[DV0+k]),
        .rem_i (dv_rem[l][k]),
        .bit_i ((k == 0) ? mag_d[l][0] : 1'b0),
        .len_i (dv_len[k]),
        .q_i   (dv_q[l][k]),
        .rem_r (dv_rem[l][k+1]),
        .q_r   (dv_q[l][k+1])
      );
    end
  end

  assign dv_len[0] = sq_root[RW];
  assign dv_deg[0] = sq_deg[RW];

  for (genvar k = 0; k < QW; k++) begin : g_dside
    logic [RW-1:0] len_r;
    logic [2:0]    neg_r;
    logic          deg_r;
    always_ff @(posedge clk) begin
      if (en[DV0+k]) begin
        len_r <= dv_len[k];
        neg_r <= dv_neg[k];
        deg_r <= dv_deg[k];
      end
    end
    assign dv_len[k+1] = len_r;
    assign dv_neg[k+1] = neg_r;
    assign dv_deg[k+1] = deg_r;
  end

  // Final stage: apply signs, force zero on a degenerate triangle
  logic signed [QW:0]         qs   [3];
  logic signed [TUN_NORM_W-1:0] comp [3];
  tun_out_t                   out_r;

  for (genvar l = 0; l < 3; l++) begin : g_pack
    assign qs[l]   = dv_neg[QW][l] ? -$signed({1'b0, dv_q[l][QW]})
                                   : $signed({1'b0, dv_q[l][QW]});
    assign comp[l] = dv_deg[QW] ? '0 : TUN_NORM_W'(qs[l]);
  end

  always_ff @(posedge clk) begin
    if (en[PK]) begin
      out_r.normal_x   <= comp[0];
      out_r.normal_y   <= comp[1];
      out_r.normal_z   <= comp[2];
      out_r.degenerate <= dv_deg[QW];
    end
  end

  assign out_data = out_r;

`ifndef SYNTHESIS
  // A degenerate result carries a zero vector
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.normal_x == '0 && out_data.normal_y == '0 && out_data.normal_z == '0)
    else $error("degenerate result with nonzero normal");

  // Input stalls only when every stage is full and the output is held
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready && (&v_r))
    else $error("input stalled with a free stage");

  // An accepted transfer lands in the first stage
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[0])
    else $error("accepted transfer lost at entry");
`endif

endmodule
